// ----- design/wgm_pkg.sv -----
// Shared types and constants for the wildcard glob matcher.
package wgm_pkg;

   localparam int PATTERN_MAX_DEF = 32;

   localparam logic [7:0] STAR_CHAR  = 8'd42;
   localparam logic [7:0] QMARK_CHAR = 8'd63;

   typedef enum logic [1:0] {
      CMD_CLEAR   = 2'd0,
      CMD_APPEND  = 2'd1,
      CMD_SUBJECT = 2'd2,
      CMD_EMPTY   = 2'd3
   } cmd_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] char_value;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic matched;
      logic pattern_too_long;
   } rsp_item_type;

endpackage

// ----- design/wildcard_glob_matcher_unit.sv -----
// Wildcard glob matcher top level: input register, position-set state and result register.
// The final transaction passes through the input register, then its result loads into the result register.
// Throughput: one transaction per cycle while the result side does not stall, limited by the position-set update.
// Synchronous active-high reset empties the pattern and drops any subject in progress.
// The pattern byte store is not cleared; only entries below the fill count are ever used.
module wildcard_glob_matcher_unit import wgm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   localparam int W    = PATTERN_MAX + 1;
   localparam int CNTW = $clog2(PATTERN_MAX + 1);

   // Input register: one transaction waits here while the state is updated.
   logic         s1_valid_ff, s1_valid_in;
   req_item_type s1_data_ff;

   // Position-set state. The live set is meaningful only while a subject is active.
   logic [W-1:0] live_ff, live_in;
   logic         active_ff, active_in;

   // Result register, which decouples the result side from the input side.
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_data_ff;

   logic         produces;
   logic         out_free;
   logic         s1_go;
   logic         accept;

   logic [PATTERN_MAX-1:0] star_mask;
   logic [PATTERN_MAX-1:0] range_mask;
   logic [PATTERN_MAX-1:0] char_hit;
   logic [CNTW-1:0]        count;
   logic                   overflow;
   logic [W-1:0]           next_set;
   logic                   hit_subject;
   logic                   hit_empty;

   // A transaction yields a result only at the final subject byte or an empty-subject command.
   assign produces = ((s1_data_ff.cmd == CMD_SUBJECT) && s1_data_ff.last)
                     || (s1_data_ff.cmd == CMD_EMPTY);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_go    = s1_valid_ff && (!produces || out_free);

   // The input register frees up in the same cycle that its transaction is processed.
   assign req_stall = s1_valid_ff && !s1_go;
   assign accept    = req_valid && !req_stall;

   wgm_pattern #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_pattern (
      .clock      (clock),
      .reset      (reset),
      .clear_en   (s1_go && (s1_data_ff.cmd == CMD_CLEAR)),
      .append_en  (s1_go && (s1_data_ff.cmd == CMD_APPEND)),
      .char_value (s1_data_ff.char_value),
      .star_mask  (star_mask),
      .range_mask (range_mask),
      .char_hit   (char_hit),
      .count      (count),
      .overflow   (overflow)
   );

   wgm_advance #(
      .PATTERN_MAX (PATTERN_MAX)
   ) u_advance (
      .live_set    (live_ff),
      .active      (active_ff),
      .star_mask   (star_mask),
      .range_mask  (range_mask),
      .char_hit    (char_hit),
      .count       (count),
      .next_set    (next_set),
      .hit_subject (hit_subject),
      .hit_empty   (hit_empty)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   // Any command other than a subject byte abandons the subject in progress.
   always_comb begin
      live_in   = live_ff;
      active_in = active_ff;
      if (s1_go) begin
         unique case (s1_data_ff.cmd)
            CMD_SUBJECT: begin
               live_in   = next_set;
               active_in = !s1_data_ff.last;
            end
            CMD_CLEAR, CMD_APPEND, CMD_EMPTY: begin
               live_in   = '0;
               active_in = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_go && produces) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         live_ff      <= '0;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         live_ff      <= live_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An overflowed pattern never reports a match.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_data_ff <= req_data;
      end
      if (s1_go && produces) begin
         rsp_data_ff.matched <= !overflow
            && ((s1_data_ff.cmd == CMD_EMPTY) ? hit_empty : hit_subject);
         rsp_data_ff.pattern_too_long <= overflow;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   property p_result_lands;
      @(posedge clock) disable iff (reset)
         (s1_go && produces) |=> rsp_valid_ff;
   endproperty
   a_result_lands: assert property (p_result_lands)
      else $error("processed transaction with a result did not load the result register");

   property p_subject_ends;
      @(posedge clock) disable iff (reset)
         (s1_go && ((s1_data_ff.cmd != CMD_SUBJECT) || s1_data_ff.last)) |=> !active_ff;
   endproperty
   a_subject_ends: assert property (p_subject_ends)
      else $error("subject still active after a final byte or another command");

   property p_no_stall_when_empty;
      @(posedge clock) disable iff (reset)
         !s1_valid_ff |-> !req_stall;
   endproperty
   a_no_stall_when_empty: assert property (p_no_stall_when_empty)
      else $error("input stalled while the input register is empty");

   property p_overflow_no_match;
      @(posedge clock) disable iff (reset)
         rsp_valid_ff |-> !(rsp_data_ff.matched && rsp_data_ff.pattern_too_long);
   endproperty
   a_overflow_no_match: assert property (p_overflow_no_match)
      else $error("match reported for an overflowed pattern");

endmodule

// ----- design/wgm_pattern.sv -----
// Pattern storage: byte store, fill count, overflow flag and per-position compare.
module wgm_pattern import wgm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               clear_en,
   input  logic                               append_en,
   input  logic [7:0]                         char_value,
   output logic [PATTERN_MAX-1:0]             star_mask,
   output logic [PATTERN_MAX-1:0]             range_mask,
   output logic [PATTERN_MAX-1:0]             char_hit,
   output logic [$clog2(PATTERN_MAX+1)-1:0]   count,
   output logic                               overflow
);

   localparam int CNTW = $clog2(PATTERN_MAX + 1);
   localparam int IDXW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

   logic [7:0]      pattern_ff [PATTERN_MAX];
   logic [CNTW-1:0] count_ff, count_in;
   logic            overflow_ff, overflow_in;
   logic            full;

   assign full = (count_ff == CNTW'(PATTERN_MAX));

   always_comb begin
      count_in    = count_ff;
      overflow_in = overflow_ff;
      if (clear_en) begin
         count_in    = '0;
         overflow_in = 1'b0;
      end else if (append_en) begin
         if (full) begin
            overflow_in = 1'b1;
         end else begin
            count_in = count_ff + CNTW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         overflow_ff <= overflow_in;
      end
   end

   // The store itself needs no reset; only entries below the count are used.
   always_ff @(posedge clock) begin
      if (append_en && !clear_en && !full) begin
         pattern_ff[count_ff[IDXW-1:0]] <= char_value;
      end
   end

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         star_mask[i]  = (pattern_ff[i] == STAR_CHAR);
         range_mask[i] = (CNTW'(i) < count_ff);
         char_hit[i]   = (pattern_ff[i] == QMARK_CHAR) || (pattern_ff[i] == char_value);
      end
   end

   assign count    = count_ff;
   assign overflow = overflow_ff;

   property p_full_append_sets_overflow;
      @(posedge clock) disable iff (reset)
         (append_en && !clear_en && full) |=> (overflow_ff && count_ff == CNTW'(PATTERN_MAX));
   endproperty
   a_full_append_sets_overflow: assert property (p_full_append_sets_overflow)
      else $error("append to a full pattern did not set overflow or changed the count");

endmodule

// ----- design/wgm_advance.sv -----
// Position-set update: one subject byte step plus star closure via a prefix network.
module wgm_advance import wgm_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
   input  logic [PATTERN_MAX:0]               live_set,
   input  logic                               active,
   input  logic [PATTERN_MAX-1:0]             star_mask,
   input  logic [PATTERN_MAX-1:0]             range_mask,
   input  logic [PATTERN_MAX-1:0]             char_hit,
   input  logic [$clog2(PATTERN_MAX+1)-1:0]   count,
   output logic [PATTERN_MAX:0]               next_set,
   output logic                               hit_subject,
   output logic                               hit_empty
);

   localparam int W      = PATTERN_MAX + 1;
   localparam int LEVELS = $clog2(W);

   // Bit j is reached if some lower live bit i is followed only by stars up to j.
   function automatic logic [W-1:0] closure(input logic [W-1:0] seed,
                                            input logic [W-1:0] prop);
      logic [W-1:0] g;
      logic [W-1:0] p;
      int           d;
      g = seed;
      p = prop;
      for (int lvl = 0; lvl < LEVELS; lvl++) begin
         d = 1 << lvl;
         for (int j = W - 1; j >= d; j--) begin
            g[j] = g[j] | (p[j] & g[j-d]);
            p[j] = p[j] & p[j-d];
         end
      end
      return g;
   endfunction

   logic [W-1:0] prop;
   logic [W-1:0] start_set;
   logic [W-1:0] base_set;
   logic [W-1:0] step_set;

   assign prop      = {star_mask & range_mask, 1'b0};
   assign start_set = closure(W'(1), prop);
   assign base_set  = active ? live_set : start_set;

   always_comb begin
      step_set = '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (base_set[i] && range_mask[i]) begin
            if (star_mask[i]) begin
               step_set[i] = 1'b1;
            end else if (char_hit[i]) begin
               step_set[i+1] = 1'b1;
            end
         end
      end
   end

   assign next_set    = closure(step_set, prop);
   assign hit_subject = next_set[count];
   assign hit_empty   = start_set[count];

endmodule
